// ===== src/a85_pkg.sv =====
// ----------------------------------------------------------------------------
// a85_pkg: shared types and constants for the Ascii85 stream decoder
// Character codes, status codes and the base-85 digit weights.
// ----------------------------------------------------------------------------
package a85_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;  // '!', digit value 0
    localparam logic [7:0] CH_U     = 8'h75;  // 'u', digit value 84
    localparam logic [7:0] CH_Z     = 8'h7a;  // 'z', four zero bytes
    localparam logic [7:0] CH_TILDE = 8'h7e;  // '~'
    localparam logic [7:0] CH_GT    = 8'h3e;  // '>'

    localparam int unsigned GROUP_DIGITS = 5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_Z_IN_GRP  = 2'd1,
        ST_BAD_TILDE = 2'd2,
        ST_BAD_CHAR  = 2'd3
    } t_status;

    // Weight of the digit at position idx of a group (85^(4-idx)).
    function automatic logic [25:0] f_weight(input logic [2:0] idx);
        logic [25:0] w;
        case (idx)
            3'd0:    w = 26'd52200625;
            3'd1:    w = 26'd614125;
            3'd2:    w = 26'd7225;
            3'd3:    w = 26'd85;
            3'd4:    w = 26'd1;
            default: w = 26'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== src/ascii85_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// ascii85_stream_decoder: Ascii85 text to binary byte stream
// Decodes one text character per request into up to four result bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one character (i_ch) and a
//   flag on the last character of the string (i_final_byte). A request is
//   taken at a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall carry one result per request:
//   a byte with its valid flag, a status code, stream_end and last_result.
//   Results of a character appear the cycle after it is taken.
//   Throughput: one character per cycle while each produces at most one
//   result and the receiver does not stall. A completed group or 'z' gives a
//   burst of four results, and the input stalls while the four-entry burst
//   register drains them at one result per cycle unless the receiver stalls.
//   The next character is taken in the same cycle the last result of a
//   burst leaves, so there are no bubbles between bursts.
//   When the receiver stalls, the current result holds and the input stalls.
//   Reset (synchronous, active low) clears the group, digit count, pending
//   '~' flag, the stream-over flag and the burst register's result count.
//   After an end or an error, characters are dropped without results until
//   one flagged final, which returns the decoder to its reset state.
// ----------------------------------------------------------------------------
module ascii85_stream_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_ch,
    input  logic              i_final_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output a85_pkg::t_status  o_status,
    output logic              o_stream_end,
    output logic              o_last_result
);
    import a85_pkg::*;

    // Decoder state
    logic [31:0] r_group, n_group;
    logic [2:0]  r_count, n_count;
    logic        r_await, n_await;
    logic        r_over,  n_over;

    // Burst register: pending results of the last request
    logic [31:0] r_word,   n_word;
    logic [2:0]  r_cnt,    n_cnt;
    logic        r_bv,     n_bv;
    t_status     r_status, n_status;
    logic        r_end,    n_end;

    logic        accept, out_fire;
    logic        is_blank, is_digit;
    logic [6:0]  digit_val;
    logic [6:0]  mul_a;
    logic [2:0]  mul_sel;
    logic [32:0] product;
    logic [31:0] sum;
    logic [2:0]  fin_bytes;
    logic        do_finish;
    logic        done;
    t_status     err;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_fire = o_out_valid && !i_out_stall;

    // Free when empty, or when the last pending result leaves this cycle.
    assign o_in_stall = (r_cnt != 3'd0) && !((r_cnt == 3'd1) && !i_out_stall);

    always_comb begin
        is_blank  = (i_ch <= CH_SPACE);
        is_digit  = i_ch inside {[CH_BANG:CH_U]};
        digit_val = 7'(i_ch - CH_BANG);
    end

    // One multiply-add serves both digits and the end-of-group padding.
    // A digit that ends a partial group on the final character folds the
    // padding weight in: old + (d+1)*w[idx].
    always_comb begin
        if (is_digit && !r_await) begin
            mul_a   = digit_val + 7'((i_final_byte && r_count != 3'd4) ? 1 : 0);
            mul_sel = r_count;
        end else begin
            mul_a   = 7'd1;
            mul_sel = r_count - 3'd1;
        end
        product = 33'(mul_a) * 33'(f_weight(mul_sel));
        sum     = r_group + product[31:0];
    end

    always_comb begin
        n_group   = r_group;
        n_count   = r_count;
        n_await   = r_await;
        n_over    = r_over;
        n_word    = '0;
        n_cnt     = 3'd0;
        n_bv      = 1'b0;
        n_status  = ST_OK;
        n_end     = 1'b0;
        err       = ST_OK;
        do_finish = 1'b0;
        fin_bytes = (r_count == 3'd0) ? 3'd0 : r_count - 3'd1;
        done      = 1'b0;

        if (r_over) begin
            if (i_final_byte) begin
                n_over = 1'b0;
            end
        end else begin
            if (r_await) begin
                done = 1'b1;
                if (i_ch == CH_GT) begin
                    do_finish = 1'b1;
                end else begin
                    err = ST_BAD_TILDE;
                end
            end else if (is_blank) begin
                do_finish = i_final_byte;
            end else if (i_ch == CH_Z) begin
                if (r_count != 3'd0) begin
                    err = ST_Z_IN_GRP;
                end else begin
                    n_word = '0;
                    n_cnt  = 3'd4;
                    n_bv   = 1'b1;
                    n_end  = i_final_byte;
                end
            end else if (i_ch == CH_TILDE) begin
                n_await = 1'b1;
                if (i_final_byte) begin
                    err = ST_BAD_TILDE;
                end
            end else if (is_digit) begin
                if (r_count == 3'(GROUP_DIGITS - 1)) begin
                    n_word  = sum;
                    n_cnt   = 3'd4;
                    n_bv    = 1'b1;
                    n_end   = i_final_byte;
                    n_group = '0;
                    n_count = 3'd0;
                end else if (i_final_byte) begin
                    // partial group closed by the final character
                    do_finish = 1'b1;
                    fin_bytes = r_count;
                end else begin
                    n_group = sum;
                    n_count = r_count + 3'd1;
                end
            end else begin
                err = ST_BAD_CHAR;
            end

            if (err != ST_OK) begin
                n_word   = '0;
                n_cnt    = 3'd1;
                n_bv     = 1'b0;
                n_status = err;
                n_end    = 1'b1;
                done     = 1'b1;
            end else if (do_finish) begin
                n_word = sum;
                n_end  = 1'b1;
                if (fin_bytes == 3'd0) begin
                    n_cnt = 3'd1;
                    n_bv  = 1'b0;
                end else begin
                    n_cnt = fin_bytes;
                    n_bv  = 1'b1;
                end
            end

            if (done || i_final_byte) begin
                n_group = '0;
                n_count = 3'd0;
                n_await = 1'b0;
                n_over  = !i_final_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group <= '0;
            r_count <= 3'd0;
            r_await <= 1'b0;
            r_over  <= 1'b0;
        end else if (accept) begin
            r_group <= n_group;
            r_count <= n_count;
            r_await <= n_await;
            r_over  <= n_over;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= n_word;
            r_bv     <= n_bv;
            r_status <= n_status;
            r_end    <= n_end;
        end else if (out_fire) begin
            r_word <= {r_word[23:0], 8'h00};
        end
    end

    assign o_out_valid   = (r_cnt != 3'd0);
    assign o_out_byte    = r_bv ? r_word[31:24] : 8'h00;
    assign o_byte_valid  = r_bv;
    assign o_status      = r_status;
    assign o_last_result = (r_cnt == 3'd1);
    assign o_stream_end  = r_end && (r_cnt == 3'd1);

endmodule

// ===== src/a85_checker.sv =====
// ----------------------------------------------------------------------------
// a85_checker: port-level checks for the Ascii85 stream decoder
// Watches the result channel and the input stall over time.
// ----------------------------------------------------------------------------
module a85_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [7:0]        o_out_byte,
    input logic              o_byte_valid,
    input a85_pkg::t_status  o_status,
    input logic              o_stream_end,
    input logic              o_last_result
);
    import a85_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_status)
            && $stable(o_last_result))
        else $error("stalled result changed");

    // error result is a lone, byteless end marker
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            !o_byte_valid && o_stream_end && o_last_result)
        else $error("error result malformed");

    // a byteless result only ever marks an end
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_valid |-> o_stream_end)
        else $error("byteless result without stream end");

    // a result other than the last is followed by more of the same burst
    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_result && !i_out_stall |=> o_out_valid)
        else $error("burst cut short");

    // nothing pending means input is never held off
    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with no pending result");

endmodule

bind ascii85_stream_decoder a85_checker u_a85_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_byte_valid  (o_byte_valid),
    .o_status      (o_status),
    .o_stream_end  (o_stream_end),
    .o_last_result (o_last_result)
);
